/* src/fhsd_pkg.sv */
// Package for the FNV-1a hash set de-duplicator.
// Holds table geometry, hash constants, field widths and the byte fold function.
// Depends on nothing; every module of the block imports it.
package fhsd_pkg;

  // BUCKETS must be a power of two so that the start slot is the low hash bits.
  localparam int unsigned BUCKETS = 4096;
  localparam int unsigned IDX_W   = $clog2(BUCKETS);
  localparam int unsigned CNT_W   = $clog2(BUCKETS + 1);
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned OCC_W   = 13;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [SYM_W-1:0]  SEP_CHAR  = 8'h7C;
  localparam logic [SYM_W-1:0]  LOWER_A   = 8'h61;
  localparam logic [SYM_W-1:0]  LOWER_Z   = 8'h7A;
  localparam logic [SYM_W-1:0]  CASE_OFS  = 8'h20;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic             seen;
    logic             table_full;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  function automatic hash_t fold_byte(hash_t h, logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] u;
    hash_t            x;
    u = b;
    if (b >= LOWER_A && b <= LOWER_Z) begin
      u = b - CASE_OFS;
    end
    x = h ^ {{(HASH_W - SYM_W){1'b0}}, u};
    return x * FNV_PRIME;
  endfunction

endpackage

/* src/fhsd_hash.sv */
// Running FNV-1a hash register with case folding and separator handling.
// Produces the finished key, with a zero hash replaced by one.
// Depends on fhsd_pkg.
module fhsd_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fold_en_i,
  input  logic                        end_en_i,
  input  logic [fhsd_pkg::SYM_W-1:0]  symbol_i,
  input  logic                        is_separator_i,
  output fhsd_pkg::hash_t             key_o
);
  import fhsd_pkg::*;

  hash_t hash_q, hash_d;

  always_comb begin
    hash_d = hash_q;
    if (end_en_i) begin
      hash_d = FNV_BASIS;
    end else if (fold_en_i) begin
      hash_d = fold_byte(hash_q, is_separator_i ? SEP_CHAR : symbol_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign key_o = (hash_q == '0) ? hash_t'(1) : hash_q;

endmodule

/* src/fhsd_probe.sv */
// Hash table memory with the clearing pass and the linear probe sequencer.
// Reads one slot per cycle, inserts on an empty slot and emits one result.
// Depends on fhsd_pkg.
module fhsd_probe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                end_en_i,
  input  fhsd_pkg::hash_t     key_i,
  output logic                busy_o,
  output logic                valid_o,
  output fhsd_pkg::result_t   result_o
);
  import fhsd_pkg::*;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StCheck
  } state_e;

  state_e  state_q, state_d;
  idx_t    idx_q, idx_d;
  idx_t    probe_q, probe_d;
  hash_t   key_q, key_d;
  cnt_t    count_q, count_d;
  logic    valid_q, valid_d;
  result_t res_q, res_d;

  hash_t   mem [BUCKETS];
  hash_t   rdata_q;
  idx_t    raddr, waddr;
  hash_t   wdata;
  logic    we;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    probe_d = probe_q;
    key_d   = key_q;
    count_d = count_q;
    valid_d = 1'b0;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = key_q;
    raddr   = idx_q + idx_t'(1);
    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + idx_t'(1);
        if (idx_q == idx_t'(BUCKETS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        raddr = key_i[IDX_W-1:0];
        if (end_en_i) begin
          key_d   = key_i;
          idx_d   = key_i[IDX_W-1:0];
          probe_d = '0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (rdata_q == '0) begin
          we      = 1'b1;
          count_d = count_q + cnt_t'(1);
          res_d   = '{seen: 1'b0, table_full: 1'b0,
                      occupancy: OCC_W'(count_q + cnt_t'(1))};
          valid_d = 1'b1;
          state_d = StIdle;
        end else if (rdata_q == key_q) begin
          res_d   = '{seen: 1'b1, table_full: 1'b0, occupancy: OCC_W'(count_q)};
          valid_d = 1'b1;
          state_d = StIdle;
        end else if (probe_q == idx_t'(BUCKETS - 1)) begin
          res_d   = '{seen: 1'b0, table_full: 1'b1, occupancy: OCC_W'(count_q)};
          valid_d = 1'b1;
          state_d = StIdle;
        end else begin
          idx_d   = idx_q + idx_t'(1);
          probe_d = probe_q + idx_t'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      probe_q <= '0;
      key_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      probe_q <= probe_d;
      key_q   <= key_d;
      count_q <= count_d;
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign busy_o   = (state_q != StIdle);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held for more than one cycle");

  a_seen_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(res_q.seen && res_q.table_full))
    else $error("seen and table_full both set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(BUCKETS))
    else $error("stored count exceeds table size");

  a_end_starts_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_en_i && state_q == StIdle) |=> (state_q == StCheck))
    else $error("end transfer did not start a probe");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.seen && !res_q.table_full) |->
      (count_q == $past(count_q) + cnt_t'(1)))
    else $error("insert did not advance the stored count");

endmodule

/* src/fnv1a_hash_set_dedup_top.sv */
// Top level of the FNV-1a hash set de-duplicator: byte stream in, one result per key.
// A name byte or separator transfer is taken while busy is low; an end transfer keeps
// busy high while the slots are probed (1 to 4096 of them), and the result strobe
// comes in the cycle after the last slot is probed, when busy is already low again.
// After reset busy stays high while the table memory is cleared.
// The receiver cannot stall: each result is flagged by valid_o for exactly one cycle.
module fnv1a_hash_set_dedup_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [fhsd_pkg::SYM_W-1:0]  symbol_i,
  input  logic                        is_separator_i,
  input  logic                        is_end_i,
  output logic                        valid_o,
  output logic                        seen_o,
  output logic                        table_full_o,
  output logic [fhsd_pkg::OCC_W-1:0]  occupancy_o
);
  import fhsd_pkg::*;

  logic    accept;
  logic    fold_en;
  logic    end_en;
  hash_t   key;
  result_t result;

  assign accept  = start && !busy;
  assign fold_en = accept && !is_end_i;
  assign end_en  = accept && is_end_i;

  fhsd_hash u_hash (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fold_en_i      (fold_en),
    .end_en_i       (end_en),
    .symbol_i       (symbol_i),
    .is_separator_i (is_separator_i),
    .key_o          (key)
  );

  fhsd_probe u_probe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .end_en_i (end_en),
    .key_i    (key),
    .busy_o   (busy),
    .valid_o  (valid_o),
    .result_o (result)
  );

  assign seen_o       = result.seen;
  assign table_full_o = result.table_full;
  assign occupancy_o  = result.occupancy;

endmodule
